// ===== hw/rtl/time_of_day_pump_scheduler_defines.svh =====
// assertion helpers shared by the scheduler rtl
`ifndef TIME_OF_DAY_PUMP_SCHEDULER_DEFINES_SVH
`define TIME_OF_DAY_PUMP_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TDPS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication, checked outside reset
`define TDPS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== hw/rtl/tdps_pkg.sv =====
package tdps_pkg;

    // field widths
    localparam int TIME_W     = 17;
    localparam int ELAPSED_W  = 18;
    localparam int SLOT_IDX_W = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_CNT_W = 5;

    // one day in seconds at two widths
    localparam logic [TIME_W-1:0]    DAY_SECONDS   = 17'd86400;
    localparam logic [ELAPSED_W-1:0] DAY_SECONDS_E = 18'd86400;

    // remainder steps, one quotient bit each
    localparam logic [STEP_CNT_W-1:0] DIV_STEPS = 5'd18;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CYCLIC = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CUSTOM = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_STOP  = 3'd4;

    // input opcodes
    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // request into the remainder unit
    typedef struct packed {
        logic                 start;
        logic [ELAPSED_W-1:0] dividend;
        logic [TIME_W-1:0]    divisor;
    } tdps_rem_req_t;

    // status out of the remainder unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TIME_W-1:0] rem;
    } tdps_rem_rsp_t;

    // slot table write
    typedef struct packed {
        logic                  en;
        logic [SLOT_IDX_W-1:0] index;
        logic [TIME_W-1:0]     start;
        logic [TIME_W-1:0]     duration;
    } tdps_slot_wr_t;

    // one result
    typedef struct packed {
        logic                  pump_on;
        logic                  in_window;
        logic [SLOT_IDX_W-1:0] matched_slot;
        logic                  period_fault;
    } tdps_result_t;

    // fold a 17-bit time into one day; inputs stay below two days
    function automatic logic [TIME_W-1:0] reduce_day(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] r;
        r = (v >= DAY_SECONDS) ? (v - DAY_SECONDS) : v;
        return r;
    endfunction

endpackage

// ===== hw/rtl/tdps_rem_unit.sv =====
`include "time_of_day_pump_scheduler_defines.svh"

module tdps_rem_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tdps_pkg::tdps_rem_req_t req,
    output tdps_pkg::tdps_rem_rsp_t rsp
);
    import tdps_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [ELAPSED_W-1:0]  dvd_reg;
    logic [TIME_W-1:0]     div_reg;
    logic [TIME_W-1:0]     rem_reg;

    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] rem_step;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[ELAPSED_W-1]};
        diff     = shifted - {1'b0, div_reg};
        rem_step = (shifted >= {1'b0, div_reg}) ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
    end

    // step counter and completion flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ELAPSED_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

    `TDPS_ASSERT_IMP(a_rem_below_div, clk, rst_n, busy_reg, (div_reg != '0) && (rem_reg < div_reg))
    `TDPS_ASSERT_NEXT(a_start_runs, clk, rst_n, req.start && !busy_reg, busy_reg && !done_reg)
    `TDPS_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, !busy_reg && (cnt_reg == '0))

endmodule

// ===== hw/rtl/tdps_slot_table.sv =====
module tdps_slot_table #(
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tdps_pkg::tdps_slot_wr_t               wr,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_index,
    input  logic [tdps_pkg::TIME_W-1:0]           now,
    output logic                                  match
);
    import tdps_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // start is kept already folded into one day
    logic [TIME_W-1:0] start_reg [DEPTH];
    logic [TIME_W-1:0] dur_reg   [DEPTH];

    logic [ELAPSED_W-1:0] s_e;
    logic [ELAPSED_W-1:0] end_e;
    logic [ELAPSED_W-1:0] now_e;
    logic [ELAPSED_W-1:0] now_next_day;

    // table write, all slots disabled after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                start_reg[i] <= '0;
                dur_reg[i]   <= '0;
            end
        end
        else if (wr.en)
        begin
            start_reg[wr.index[IDX_W-1:0]] <= reduce_day(wr.start);
            dur_reg[wr.index[IDX_W-1:0]]   <= wr.duration;
        end
    end

    // today's run or yesterday's spill past midnight
    always_comb
    begin
        s_e          = {1'b0, start_reg[rd_index]};
        end_e        = s_e + {1'b0, dur_reg[rd_index]};
        now_e        = {1'b0, now};
        now_next_day = now_e + DAY_SECONDS_E;
        match        = (dur_reg[rd_index] != '0) &&
                       (((now_e >= s_e) && (now_e < end_e)) || (now_next_day < end_e));
    end

endmodule

// ===== hw/rtl/time_of_day_pump_scheduler.sv =====
// Time-of-day pump scheduler.
// Input stream (s_*): one transaction is either an evaluate tick (s_tuser = 0)
// carrying the time of day, or a slot load (s_tuser = 1) writing one custom slot.
// Output stream (m_*): one result per evaluate tick, none per load.
// Configuration: cfg_we writes register cfg_index with cfg_wdata; write it only
// while no tick is in flight.
// Sequence: a load is written to the slot table straight from idle. An evaluate
// tick in off or on mode goes straight to the finish state; custom mode scans
// one slot per cycle, up to min(SLOT_COUNT, 8) slots; cyclic mode, inside the
// window, runs the elapsed time through an 18-step shift-subtract remainder unit.
// s_tready is high only between items, so no item is taken while one is in work.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver stalls, the following result waits in the
// sequencer and input stays blocked until the output register frees up.
// Reset clears the control and configuration registers and the slot table, so every slot is disabled.
`include "time_of_day_pump_scheduler_defines.svh"

module time_of_day_pump_scheduler #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // time_of_day[16:0], slot_index[19:17], slot_start[36:20],
    // slot_duration[53:37], zero pad [55:54]
    input  logic [55:0]                        s_tdata,
    // opcode[0]
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pump_on[0], in_window[1], matched_slot[4:2], period_fault[5], zero pad [7:6]
    output logic [7:0]                         m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [tdps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdps_pkg::TIME_W-1:0]        cfg_wdata
);
    import tdps_pkg::*;

    localparam int TABLE_DEPTH = (SLOT_COUNT < (2 ** SLOT_IDX_W)) ? SLOT_COUNT
                                                                   : (2 ** SLOT_IDX_W);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CYC_SETUP = 3'd1;
    localparam logic [2:0] ST_CYC_DIV   = 3'd2;
    localparam logic [2:0] ST_SCAN      = 3'd3;
    localparam logic [2:0] ST_FINISH    = 3'd4;

    // configuration
    logic [MODE_W-1:0] mode_reg;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] duty_reg;
    logic [TIME_W-1:0] win_start_reg;
    logic [TIME_W-1:0] win_stop_reg;

    // sequencer
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [TIME_W-1:0] now_reg, now_next;
    tdps_result_t     res_reg, res_next;
    tdps_result_t     out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    tdps_rem_req_t rem_req;
    tdps_rem_rsp_t rem_rsp;
    tdps_slot_wr_t slot_wr;
    logic          slot_match;

    logic                 wrap;
    logic                 now_lt_stop;
    logic                 win_hit;
    logic [ELAPSED_W-1:0] elapsed_base;
    logic [ELAPSED_W-1:0] elapsed;

    // configuration writes, window times folded into one day
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            period_reg    <= '0;
            duty_reg      <= '0;
            win_start_reg <= '0;
            win_stop_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:      mode_reg      <= cfg_wdata[MODE_W-1:0];
                CFG_PERIOD:    period_reg    <= cfg_wdata;
                CFG_DUTY:      duty_reg      <= cfg_wdata;
                CFG_WIN_START: win_start_reg <= reduce_day(cfg_wdata);
                CFG_WIN_STOP:  win_stop_reg  <= reduce_day(cfg_wdata);
                default:       ;
            endcase
        end
    end

    // window test and elapsed time since the window opened
    always_comb
    begin
        wrap         = (win_start_reg >= win_stop_reg);
        now_lt_stop  = (now_reg < win_stop_reg);
        win_hit      = wrap ? (now_lt_stop || (now_reg >= win_start_reg))
                            : (now_lt_stop && (now_reg >= win_start_reg));
        elapsed_base = {1'b0, now_reg} + ((wrap && now_lt_stop) ? DAY_SECONDS_E : '0);
        elapsed      = elapsed_base - {1'b0, win_start_reg};
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        now_next       = now_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        rem_req.start    = 1'b0;
        rem_req.dividend = elapsed;
        rem_req.divisor  = period_reg;

        slot_wr.en       = 1'b0;
        slot_wr.index    = s_tdata[19:17];
        slot_wr.start    = s_tdata[36:20];
        slot_wr.duration = s_tdata[53:37];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_LOAD)
                    begin
                        slot_wr.en = (int'(s_tdata[19:17]) < SLOT_COUNT);
                    end
                    else
                    begin
                        now_next  = reduce_day(s_tdata[16:0]);
                        res_next  = '0;
                        scan_next = '0;
                        case (mode_reg)
                            MODE_ON:
                            begin
                                res_next.pump_on = 1'b1;
                                state_next       = ST_FINISH;
                            end
                            MODE_CYCLIC: state_next = ST_CYC_SETUP;
                            MODE_CUSTOM: state_next = ST_SCAN;
                            default:     state_next = ST_FINISH;
                        endcase
                    end
                end
            end
            ST_CYC_SETUP:
            begin
                res_next.in_window = win_hit;
                if (!win_hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (period_reg == '0)
                begin
                    res_next.period_fault = 1'b1;
                    state_next            = ST_FINISH;
                end
                else
                begin
                    rem_req.start = 1'b1;
                    state_next    = ST_CYC_DIV;
                end
            end
            ST_CYC_DIV:
            begin
                if (rem_rsp.done)
                begin
                    res_next.pump_on = (rem_rsp.rem < duty_reg);
                    state_next       = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (slot_match)
                begin
                    res_next.pump_on      = 1'b1;
                    res_next.in_window    = 1'b1;
                    res_next.matched_slot = SLOT_IDX_W'(scan_reg);
                    state_next            = ST_FINISH;
                end
                else if (scan_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    tdps_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    tdps_slot_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (slot_wr),
        .rd_index (scan_reg),
        .now      (now_reg),
        .match    (slot_match)
    );

    // output ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.period_fault, out_reg.matched_slot,
                       out_reg.in_window, out_reg.pump_on};

    `TDPS_ASSERT_IMP(a_fault_pump_off, clk, rst_n, out_valid_reg && out_reg.period_fault, out_reg.in_window && !out_reg.pump_on)
    `TDPS_ASSERT_IMP(a_match_runs, clk, rst_n, out_valid_reg && (out_reg.matched_slot != '0), out_reg.pump_on && out_reg.in_window)
    `TDPS_ASSERT_NEXT(a_div_launch, clk, rst_n, rem_req.start, (state_reg == ST_CYC_DIV) && rem_rsp.busy)

endmodule

// ===== tb/tdps_pump_checker.sv =====
`timescale 1ns / 100ps

module tdps_pump_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    // time_of_day[16:0], slot_index[19:17], slot_start[36:20],
    // slot_duration[53:37], zero pad [55:54]
    input  logic [55:0]                    s_tdata,
    // opcode[0]
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // pump_on[0], in_window[1], matched_slot[4:2], period_fault[5], zero pad [7:6]
    input  logic [7:0]                     m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [tdps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdps_pkg::TIME_W-1:0]    cfg_wdata,
    output int                             fail_count,
    output int                             pending_results
);
    import tdps_pkg::*;

    localparam longint DAY_LEN    = 86400;
    localparam int     SLOT_TOTAL = 8;

    // shadow copy of the configuration and the slot table
    logic [MODE_W-1:0]     mode_reg;
    logic [TIME_W-1:0]     period_reg;
    logic [TIME_W-1:0]     duty_reg;
    logic [TIME_W-1:0]     win_start_reg;
    logic [TIME_W-1:0]     win_stop_reg;
    logic [TIME_W-1:0]     slot_begin_mem [SLOT_TOTAL];
    logic [TIME_W-1:0]     slot_len_mem [SLOT_TOTAL];

    tdps_result_t          expected_decisions [$];
    tdps_result_t          want;
    logic [SLOT_IDX_W-1:0] load_idx;

    task automatic report_mismatch(input string what);
        $display("%0t ERROR %s", $time, what);
        fail_count++;
    endtask

    // decision for one tick under the current shadow state
    function automatic tdps_result_t pump_decision(input logic [TIME_W-1:0] tod);
        tdps_result_t r;
        longint       now;
        longint       win_open;
        longint       win_close;
        longint       slot_from;
        longint       slot_to;
        logic         found;
        r     = '0;
        found = 1'b0;
        now   = longint'(tod) % DAY_LEN;
        case (mode_reg)
            MODE_ON:
            begin
                r.pump_on = 1'b1;
            end
            MODE_CYCLIC:
            begin
                win_open  = longint'(win_start_reg) % DAY_LEN;
                win_close = longint'(win_stop_reg) % DAY_LEN;
                // window crossing midnight, or open all day when equal
                if (win_open >= win_close)
                begin
                    if (now < win_close)
                        win_open = win_open - DAY_LEN;
                    else
                        win_close = win_close + DAY_LEN;
                end
                if (now >= win_open && now < win_close)
                begin
                    r.in_window = 1'b1;
                    if (period_reg == '0)
                        r.period_fault = 1'b1;
                    else if ((now - win_open) % longint'(period_reg) < longint'(duty_reg))
                        r.pump_on = 1'b1;
                end
            end
            MODE_CUSTOM:
            begin
                // first enabled slot that covers now, today or spilled from yesterday
                for (int i = 0; i < SLOT_TOTAL; i++)
                begin
                    slot_from = longint'(slot_begin_mem[i]) % DAY_LEN;
                    slot_to   = slot_from + longint'(slot_len_mem[i]);
                    if (!found && slot_len_mem[i] != '0 &&
                        ((now >= slot_from && now < slot_to) ||
                         (now >= slot_from - DAY_LEN && now < slot_to - DAY_LEN)))
                    begin
                        found          = 1'b1;
                        r.pump_on      = 1'b1;
                        r.in_window    = 1'b1;
                        r.matched_slot = i[SLOT_IDX_W-1:0];
                    end
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // watch both channels and the configuration port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      = MODE_OFF;
            period_reg    = '0;
            duty_reg      = '0;
            win_start_reg = '0;
            win_stop_reg  = '0;
            for (int i = 0; i < SLOT_TOTAL; i++)
            begin
                slot_begin_mem[i] = '0;
                slot_len_mem[i]   = '0;
            end
            expected_decisions.delete();
            fail_count      = 0;
            pending_results <= 0;
        end
        else
        begin
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                if (expected_decisions.size() == 0)
                begin
                    report_mismatch($sformatf("result %h with no tick pending", m_tdata));
                end
                else
                begin
                    want = expected_decisions.pop_front();
                    if (m_tdata[0] !== want.pump_on)
                        report_mismatch($sformatf("pump_on %b, expected %b",
                                                  m_tdata[0], want.pump_on));
                    if (m_tdata[1] !== want.in_window)
                        report_mismatch($sformatf("in_window %b, expected %b",
                                                  m_tdata[1], want.in_window));
                    if (m_tdata[4:2] !== want.matched_slot)
                        report_mismatch($sformatf("matched_slot %0d, expected %0d",
                                                  m_tdata[4:2], want.matched_slot));
                    if (m_tdata[5] !== want.period_fault)
                        report_mismatch($sformatf("period_fault %b, expected %b",
                                                  m_tdata[5], want.period_fault));
                end
            end

            // input transaction: slot load or evaluate tick
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_LOAD)
                begin
                    load_idx                 = s_tdata[19:17];
                    slot_begin_mem[load_idx] = s_tdata[36:20];
                    slot_len_mem[load_idx]   = s_tdata[53:37];
                end
                else
                begin
                    expected_decisions.push_back(pump_decision(s_tdata[16:0]));
                end
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:      mode_reg      = cfg_wdata[MODE_W-1:0];
                    CFG_PERIOD:    period_reg    = cfg_wdata;
                    CFG_DUTY:      duty_reg      = cfg_wdata;
                    CFG_WIN_START: win_start_reg = cfg_wdata;
                    CFG_WIN_STOP:  win_stop_reg  = cfg_wdata;
                    default:       mode_reg      = mode_reg;
                endcase
            end

            pending_results <= expected_decisions.size();
        end
    end

endmodule

// ===== tb/tb_time_of_day_pump_scheduler.sv =====
`timescale 1ns / 100ps

module tb_time_of_day_pump_scheduler;
    import tdps_pkg::*;

    localparam int          DAY_LEN       = 86400;
    localparam logic [16:0] TIME_MAX      = 17'h1FFFF;
    localparam int          PHASE_COUNT   = 12;
    localparam int          PHASE_ITEMS   = 105;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          CYCLE_LIMIT   = 400000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic [55:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_wdata = '0;
    logic                 calm      = 1'b0;
    int                   fail_count;
    int                   pending_results;
    int                   cycle_count = 0;
    // window edges and slot edges, used to aim ticks at boundaries
    int unsigned          hot_times [18];

    always #10 clk = ~clk;

    time_of_day_pump_scheduler #(
        .SLOT_COUNT(8)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tdps_pump_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 36);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // time of day, mostly in range, sometimes at the ends or past one day
    function automatic logic [16:0] rand_time();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 17'd0;
        else if (pick < 20)
            return 17'd86399;
        else if (pick < 30)
            return 17'($urandom_range(86400, 131071));
        else
            return 17'($urandom_range(0, 86399));
    endfunction

    // length in seconds for periods, duty and slot durations
    function automatic logic [16:0] rand_span();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 17'd0;
        else if (pick < 50)
            return 17'($urandom_range(1, 600));
        else if (pick < 80)
            return 17'($urandom_range(601, 20000));
        else if (pick < 90)
            return 17'($urandom_range(20001, 86399));
        else if (pick < 95)
            return 17'd86400;
        else
            return 17'($urandom_range(86401, 131071));
    endfunction

    // one input transaction, with random gaps ahead of it
    task automatic push_item(input logic op, input logic [55:0] data);
        while (!calm && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= data;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic push_eval(input logic [16:0] tod);
        logic [55:0] d;
        d        = 56'({$urandom, $urandom});
        d[16:0]  = tod;
        d[55:54] = 2'b00;
        push_item(OP_EVAL, d);
    endtask

    task automatic push_load(input logic [2:0] idx, input logic [16:0] from,
                             input logic [16:0] span);
        logic [55:0] d;
        d        = 56'({$urandom, $urandom});
        d[19:17] = idx;
        d[36:20] = from;
        d[53:37] = span;
        d[55:54] = 2'b00;
        hot_times[2 * int'(idx)]     = from % DAY_LEN;
        hot_times[2 * int'(idx) + 1] = (from % DAY_LEN + span) % DAY_LEN;
        push_item(OP_LOAD, d);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // full register set, written while the block is idle
    task automatic set_config(input logic [1:0] mode, input logic [16:0] period,
                              input logic [16:0] duty, input logic [16:0] win_open,
                              input logic [16:0] win_close);
        logic [16:0] mode_word;
        mode_word      = 17'($urandom);
        mode_word[1:0] = mode;
        put_reg(CFG_MODE, mode_word);
        put_reg(CFG_PERIOD, period);
        put_reg(CFG_DUTY, duty);
        put_reg(CFG_WIN_START, win_open);
        put_reg(CFG_WIN_STOP, win_close);
        cfg_we        <= 1'b0;
        hot_times[16] = win_open % DAY_LEN;
        hot_times[17] = win_close % DAY_LEN;
    endtask

    // wait out every pending result, then let a late load finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [1:0]  mode;
        logic [16:0] period;
        logic [16:0] duty;
        logic [16:0] win_open;
        logic [16:0] win_close;
        logic [16:0] tod;
        int unsigned pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration is always off, also for a time past one day
        push_eval(17'd0);
        push_eval(TIME_MAX);
        settle();
        set_config(MODE_ON, 17'd0, 17'd0, 17'd0, 17'd0);
        push_eval(17'd86399);
        settle();

        // zero period raises the fault inside the window only
        set_config(MODE_CYCLIC, 17'd0, 17'd5, 17'd100, 17'd200);
        push_eval(17'd150);
        push_eval(17'd50);
        settle();

        // window across midnight, 3 s on out of every 10 s
        set_config(MODE_CYCLIC, 17'd10, 17'd3, 17'd86000, 17'd500);
        push_eval(17'd86000);
        push_eval(17'd86005);
        push_eval(17'd100);
        push_eval(17'd499);
        push_eval(17'd500);
        settle();

        // window registers past one day fold to equal values, open all day
        set_config(MODE_CYCLIC, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
        push_eval(17'd0);
        push_eval(17'd44671);
        settle();

        // custom table: disabled slot, late slot spilling past midnight
        set_config(MODE_CUSTOM, 17'd0, 17'd0, 17'd0, 17'd0);
        push_load(3'd3, 17'd1000, 17'd0);
        push_load(3'd7, 17'd86399, 17'd2);
        push_eval(17'd1000);
        push_eval(17'd0);
        push_eval(17'd86399);
        push_eval(17'd1);
        // start past one day with the longest duration covers the whole day
        push_load(3'd0, TIME_MAX, TIME_MAX);
        push_eval(17'd1);

        // random phases, each with its own configuration
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            settle();
            mode = 2'(phase % 4);
            if (phase == 2)
            begin
                period    = 17'd0;
                duty      = 17'd0;
                win_open  = 17'd0;
                win_close = 17'd0;
            end
            else if (phase == 10)
            begin
                period    = TIME_MAX;
                duty      = TIME_MAX;
                win_open  = TIME_MAX;
                win_close = TIME_MAX;
            end
            else
            begin
                period    = rand_span();
                duty      = ($urandom_range(0, 1) != 0) ? 17'($urandom_range(0, period))
                                                        : rand_span();
                win_open  = rand_time();
                win_close = rand_time();
            end
            set_config(mode, period, duty, win_open, win_close);
            calm <= (phase == 7);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if ((mode == MODE_CUSTOM && pick < 25) || pick < 4)
                begin
                    push_load(3'($urandom_range(0, 7)), rand_time(), rand_span());
                end
                else
                begin
                    // aim about a third of the ticks at a window or slot edge
                    if ($urandom_range(0, 99) < 35)
                        tod = 17'((hot_times[$urandom_range(0, 17)] + DAY_LEN
                                   + $urandom_range(0, 6) - 3) % DAY_LEN);
                    else
                        tod = rand_time();
                    push_eval(tod);
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tdps_pkg.sv
hw/rtl/tdps_rem_unit.sv
hw/rtl/tdps_slot_table.sv
hw/rtl/time_of_day_pump_scheduler.sv
tb/tdps_pump_checker.sv
tb/tb_time_of_day_pump_scheduler.sv
